[src/pcfd_pkg.sv]
// Shared widths for the parity-checked frame deframer.
// No dependencies; imported by the deframer, its result checker and the testbench.
package pcfd_pkg;

    localparam int S_TDATA_W   = 8;   // raw stream byte
    localparam int CHAR_W      = 7;   // payload character, parity bit stripped
    localparam int ERR_TOTAL_W = 16;  // error total as shown on the result
    localparam int LEN_W       = 8;   // frame length byte

    // Internal error counter width, legal range 8 to 32.
    localparam int ERR_COUNT_W = 16;

    // Result tdata: out_char then error_total, padded to whole bytes.
    localparam int M_TDATA_USED = CHAR_W + ERR_TOTAL_W;
    localparam int M_TDATA_W    = ((M_TDATA_USED + 7) / 8) * 8;
    localparam int M_TUSER_W    = 1;

endpackage

[src/parity_checked_frame_deframer.sv]
// Parity-checked frame deframer: strips two control bytes and a length byte
// per frame, then checks odd parity on each payload byte. Depends on pcfd_pkg.
//
//  channel | direction | payload
//  s_      | in        | tdata[7:0] = in_byte
//  m_      | out       | tdata[6:0] = out_char, tdata[22:7] = error_total,
//          |           | tuser[0] = parity_error, tlast = frame_last
//
// One byte is taken per cycle unless a payload byte waits for room in the result
// stage; a payload byte's result is written to the result register as it leaves the input register.
// The input register and the result register each hold one item; while a result
// waits on m_tready, a byte is still taken unless a payload byte is held in the
// input register. Header bytes never wait on m_. aresetn is synchronous and
// active low; it clears frame position, length and the error counter.
module parity_checked_frame_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pcfd_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] in_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pcfd_pkg::M_TDATA_W-1:0] m_tdata,   // [6:0] out_char, [22:7] error_total
    output logic [pcfd_pkg::M_TUSER_W-1:0] m_tuser,   // [0] parity_error
    output logic                           m_tlast
);
    import pcfd_pkg::*;

    typedef enum logic [1:0] {
        POS_CTRL0,
        POS_CTRL1,
        POS_LEN,
        POS_DATA
    } pos_t;

    // Input stage
    logic                   in_valid_reg;
    logic [S_TDATA_W-1:0]   in_byte_reg;

    // Frame state
    pos_t                   pos_reg,        pos_next;
    logic [LEN_W-1:0]       bytes_left_reg, bytes_left_next;
    logic [ERR_COUNT_W-1:0] err_count_reg,  err_count_next;

    // Result stage
    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      out_char_reg,   out_char_next;
    logic                   perr_reg,       perr_next;
    logic [ERR_TOTAL_W-1:0] err_total_reg,  err_total_next;
    logic                   last_reg,       last_next;

    logic out_free;
    logic emit;
    logic advance;
    logic s_accept;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        pos_next        = pos_reg;
        bytes_left_next = bytes_left_reg;
        err_count_next  = err_count_reg;
        out_char_next   = in_byte_reg[CHAR_W-1:0];
        perr_next       = ~(^in_byte_reg);
        err_total_next  = ERR_TOTAL_W'(err_count_reg);
        last_next       = 1'b0;
        emit            = 1'b0;
        case (pos_reg)
            POS_CTRL0: begin
                pos_next = POS_CTRL1;
            end
            POS_CTRL1: begin
                pos_next = POS_LEN;
            end
            POS_LEN: begin
                bytes_left_next = in_byte_reg;
                pos_next        = (in_byte_reg == '0) ? POS_CTRL0 : POS_DATA;
            end
            POS_DATA: begin
                if (bytes_left_reg == '0) begin
                    // no bytes left: treat as first control byte
                    pos_next = POS_CTRL1;
                end else begin
                    emit = 1'b1;
                    if (perr_next && (err_count_reg != '1)) begin
                        err_count_next = err_count_reg + 1'b1;
                    end
                    bytes_left_next = bytes_left_reg - 1'b1;
                    last_next       = (bytes_left_reg == LEN_W'(1));
                    pos_next        = last_next ? POS_CTRL0 : POS_DATA;
                    err_total_next  = ERR_TOTAL_W'(err_count_next);
                end
            end
            default: begin
                pos_next = POS_CTRL0;
            end
        endcase
    end

    // Header bytes advance freely; payload bytes need room in the result stage.
    assign advance  = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pos_reg        <= POS_CTRL0;
            bytes_left_reg <= '0;
            err_count_reg  <= '0;
        end else begin
            if (s_accept) begin
                in_byte_reg <= s_tdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                pos_reg        <= pos_next;
                bytes_left_reg <= bytes_left_next;
                err_count_reg  <= err_count_next;
            end
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
                out_char_reg  <= out_char_next;
                perr_reg      <= perr_next;
                err_total_reg <= err_total_next;
                last_reg      <= last_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({err_total_reg, out_char_reg});
    assign m_tuser  = perr_reg;
    assign m_tlast  = last_reg;

    // A flagged result implies the counter has counted at least once.
    a_err_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && perr_reg |-> err_count_reg != '0)
        else $error("parity error shown with zero error count");

    // Payload position always has bytes outstanding.
    a_data_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg == POS_DATA |-> bytes_left_reg != '0)
        else $error("payload position with no bytes left");

    // The error counter never goes backward outside reset.
    a_count_monotonic: assert property (@(posedge aclk)
        aresetn && $past(aresetn) |-> err_count_reg >= $past(err_count_reg))
        else $error("error count decreased");

    // A payload byte blocked by a full result stage stays in the input stage.
    a_hold_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && emit && !out_free |=> in_valid_reg && $stable(in_byte_reg))
        else $error("blocked payload byte lost");

endmodule

[test/deframer_result_checker.sv]
`timescale 1ns / 1ps
// Checker for the parity-checked frame deframer: tracks the frame position and
// error count from the accepted bytes and compares each result item. Uses pcfd_pkg.
module deframer_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [pcfd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pcfd_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [pcfd_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                           m_tlast,
    output int unsigned                    failures,
    output int unsigned                    outstanding,
    output int unsigned                    results_seen
);
    import pcfd_pkg::*;

    typedef enum logic [1:0] {AWAIT_CTRL0, AWAIT_CTRL1, AWAIT_LEN, IN_PAYLOAD} frame_pos_t;

    typedef struct packed {
        logic                   emits;
        logic [CHAR_W-1:0]      ch;
        logic                   perr;
        logic [ERR_TOTAL_W-1:0] total;
        logic                   last;
    } char_result_t;

    localparam logic [ERR_COUNT_W-1:0] ERR_COUNT_MAX = '1;

    frame_pos_t             frame_pos;
    logic [LEN_W-1:0]       payload_left;
    logic [ERR_COUNT_W-1:0] parity_errors;
    char_result_t           expected_chars[$];

    // Advance the frame tracker by one byte; emits is set for payload bytes.
    function automatic char_result_t deframe_byte(input logic [S_TDATA_W-1:0] b);
        char_result_t res;
        frame_pos_t   pos;
        logic [31:0]  wide_count;
        res = '0;
        pos = frame_pos;
        // a payload state with nothing left restarts the header
        if (pos == IN_PAYLOAD && payload_left == '0)
            pos = AWAIT_CTRL0;
        case (pos)
            AWAIT_CTRL0: frame_pos = AWAIT_CTRL1;
            AWAIT_CTRL1: frame_pos = AWAIT_LEN;
            AWAIT_LEN: begin
                payload_left = b;
                frame_pos = (b == '0) ? AWAIT_CTRL0 : IN_PAYLOAD;
            end
            default: begin
                res.perr = ~^b;
                if (res.perr && parity_errors != ERR_COUNT_MAX)
                    parity_errors = parity_errors + 1'b1;
                payload_left = payload_left - 1'b1;
                wide_count = 32'(parity_errors);
                res.emits = 1'b1;
                res.ch    = b[CHAR_W-1:0];
                res.total = wide_count[ERR_TOTAL_W-1:0];
                res.last  = (payload_left == '0);
                frame_pos = res.last ? AWAIT_CTRL0 : IN_PAYLOAD;
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        char_result_t res;
        char_result_t want;
        if (!aresetn) begin
            frame_pos     = AWAIT_CTRL0;
            payload_left  = '0;
            parity_errors = '0;
            expected_chars.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                res = deframe_byte(s_tdata);
                if (res.emits)
                    expected_chars.push_back(res);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_chars.size() == 0) begin
                    $error("unexpected result item: char %0d total %0d",
                           m_tdata[CHAR_W-1:0], m_tdata[CHAR_W +: ERR_TOTAL_W]);
                    failures++;
                end else begin
                    want = expected_chars.pop_front();
                    check_field("out_char", want.ch, m_tdata[CHAR_W-1:0]);
                    check_field("parity_error", want.perr, m_tuser[0]);
                    check_field("error_total", want.total, m_tdata[CHAR_W +: ERR_TOTAL_W]);
                    check_field("frame_last", want.last, m_tlast);
                end
            end
        end
        outstanding <= expected_chars.size();
    end

endmodule

[test/parity_checked_frame_deframer_tb.sv]
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte stream and result-side
// backpressure. Depends on pcfd_pkg, the deframer and deframer_result_checker.
module parity_checked_frame_deframer_tb;
    import pcfd_pkg::*;

    localparam int unsigned ITEM_TARGET = 1650;
    localparam int unsigned STEADY_FROM = 1450;
    localparam int unsigned PRESSURE_AT = 400;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // zero-length frame, parity corner bytes, then a one-byte frame
    localparam logic [7:0] DIRECTED_BYTES [16] = '{
        8'h00, 8'hFF, 8'h00,
        8'hFF, 8'h00, 8'h06, 8'h80, 8'h00, 8'hFF, 8'h7F, 8'h01, 8'hFE,
        8'h55, 8'hAA, 8'h01, 8'h03
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    int unsigned failures;
    int unsigned outstanding;
    int unsigned results_seen;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned frames_sent = 3;
    int unsigned empty_frames = 1;
    int unsigned bad_parity_sent = 0;
    bit          steady = 1'b0;
    bit          hold_off_req = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    parity_checked_frame_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    deframer_result_checker result_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .failures     (failures),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        // no sender gaps while the receiver is held off or near the end
        if (!steady && !(bytes_sent >= PRESSURE_AT && bytes_sent < PRESSURE_AT + 60)
                && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        if (bytes_sent == PRESSURE_AT)
            hold_off_req = 1'b1;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Receiver: random stall bursts, one long hold-off on request.
    initial begin
        int unsigned span;
        bit          hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                span = $urandom_range(1, 9);
                repeat (span - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                span = $urandom_range(0, 12);
                repeat (span) @(negedge aclk);
            end
        end
    end

    initial begin
        int unsigned pick;
        int unsigned len;
        logic [6:0]  data;
        logic [7:0]  b;
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        foreach (DIRECTED_BYTES[i])
            push_byte(DIRECTED_BYTES[i]);

        while (bytes_sent < ITEM_TARGET) begin
            if (bytes_sent >= STEADY_FROM)
                steady = 1'b1;
            pick = $urandom_range(0, 39);
            if (frames_sent == 5)
                len = 255;
            else if (pick == 0)
                len = $urandom_range(64, 255);
            else if (pick <= 5)
                len = 0;
            else
                len = $urandom_range(1, 8);
            frames_sent++;
            if (len == 0)
                empty_frames++;
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'(len));
            for (int unsigned i = 0; i < len; i++) begin
                data = 7'($urandom_range(0, 127));
                case ($urandom_range(0, 2))
                    0:       b = 8'($urandom_range(0, 255));
                    1:       b = {~^data, data};   // odd parity held
                    default: b = {^data, data};    // parity broken
                endcase
                if (~^b)
                    bad_parity_sent++;
                push_byte(b);
            end
        end
        @(negedge aclk) s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("summary: %0d bytes in %0d frames (%0d empty, one of 255 payload bytes)",
                 bytes_sent, frames_sent, empty_frames);
        $display("summary: %0d result items checked, %0d random payload bytes with bad parity",
                 results_seen, bad_parity_sent);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
src/pcfd_pkg.sv
src/parity_checked_frame_deframer.sv
test/deframer_result_checker.sv
test/parity_checked_frame_deframer_tb.sv
